/* rtl/bnc_pkg.sv */
// shared types for the binomial nondivisible count block
// operand and result structs used by the top level; no dependencies
package bnc_pkg;

  localparam int M_W     = 64;
  localparam int RADIX_W = 5;

  typedef struct packed {
    logic [M_W-1:0]     m_value;
    logic [RADIX_W-1:0] radix;
  } operands_t;

  typedef struct packed {
    logic [M_W-1:0] miss_total;
    logic [M_W-1:0] hit_total;
    logic [M_W-1:0] interval_total;
  } result_t;

endpackage

/* rtl/bnc_div.sv */
// iterative restoring divider: 64-bit dividend by a small base
// retires eight quotient bits per cycle; uses bnc_pkg for widths
module bnc_div import bnc_pkg::*; #(
  parameter int BASE_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [M_W-1:0]    dividend,
  input  logic [BASE_W-1:0] divisor,
  output logic              done,
  output logic [M_W-1:0]    quotient,
  output logic [BASE_W-1:0] remainder
);

  localparam int STEPS  = 8;
  localparam int CYCLES = M_W / STEPS;
  localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [M_W-1:0]    q;
  logic [BASE_W-1:0] r;
  logic [M_W-1:0]    q_next;
  logic [BASE_W-1:0] r_next;

  // eight restoring steps on a narrow partial remainder
  always_comb begin
    logic [BASE_W:0] t;
    q_next = q;
    r_next = r;
    for (int i = 0; i < STEPS; i++) begin
      t = {r_next, q_next[M_W-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q_next = {q_next[M_W-2:0], 1'b1};
      end else begin
        q_next = {q_next[M_W-2:0], 1'b0};
      end
      r_next = t[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        q       <= dividend;
        r       <= '0;
      end else if (running) begin
        q   <= q_next;
        r   <= r_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CYCLES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

/* rtl/binomial_nondivisible_counts.sv */
// top level: digit expansion of m and the three nondivisible counts
// depends on bnc_pkg and bnc_div
//
// usage: drive operands and raise start; the transfer happens at a clock edge
// where start is high and busy is low. busy then stays high until the result
// is out. the result appears on result for exactly one cycle with done high;
// the receiver cannot stall it and must take it in that cycle.
// the radix is clamped to 2..MAX_BASE.
// m is split into base digits, low digit first, by a shared divider that
// retires eight quotient bits per cycle. each digit then passes through one
// shared 64-bit by small multiplier (miss product, then interval count) and
// a zero test. m has up to 64 base digits (base 2), none for m = 0; one
// item at a time, busy for the whole item.
// a new transfer may be taken in the cycle where done is high.
// reset (rst, synchronous) returns the sequencer to idle and drops done;
// no state is kept between items.
module binomial_nondivisible_counts import bnc_pkg::*; #(
  parameter int MAX_BASE = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  operands_t operands,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  localparam int BW = $clog2(MAX_BASE + 1);

  typedef enum logic [2:0] {
    IDLE,
    TEST,
    DIV,
    MUL_MISS,
    MUL_RUNS
  } state_t;

  state_t          state;
  logic [M_W-1:0]  m_keep;
  logic [M_W-1:0]  q;
  logic [BW-1:0]   base;
  logic [BW-1:0]   d;
  logic [M_W-1:0]  miss;
  logic [M_W-1:0]  runs;
  logic            low_all_max;
  logic            first;

  logic [31:0]       radix_ext;
  logic [BW-1:0]     base_in;
  logic              div_start;
  logic              div_done;
  logic [M_W-1:0]    div_q;
  logic [BW-1:0]     div_r;
  logic [BW-1:0]     d_inc;
  logic [M_W-1:0]    mul_a;
  logic [M_W+BW-1:0] prod_full;
  logic [M_W-1:0]    prod;

  always_comb begin
    radix_ext = 32'(operands.radix);
    if (radix_ext < 32'd2) begin
      base_in = BW'(2);
    end else if (radix_ext > 32'(MAX_BASE)) begin
      base_in = BW'(MAX_BASE);
    end else begin
      base_in = radix_ext[BW-1:0];
    end
  end

  assign div_start = (state == TEST) && (q != '0);

  bnc_div #(.BASE_W(BW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (q),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // shared multiplier: miss product, then interval count
  assign d_inc     = d + BW'(1);
  assign mul_a     = (state == MUL_MISS) ? miss : runs;
  assign prod_full = mul_a * d_inc;
  assign prod      = prod_full[M_W-1:0];

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            m_keep      <= operands.m_value;
            q           <= operands.m_value;
            base        <= base_in;
            miss        <= M_W'(1);
            runs        <= '0;
            low_all_max <= 1'b1;
            first       <= 1'b1;
            state       <= TEST;
          end
        end
        TEST: begin
          if (q == '0) begin
            result.miss_total     <= miss;
            result.hit_total      <= m_keep - miss + M_W'(1);
            result.interval_total <= runs;
            done                  <= 1'b1;
            state                 <= IDLE;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_done) begin
            q     <= div_q;
            d     <= div_r;
            state <= MUL_MISS;
          end
        end
        MUL_MISS: begin
          miss  <= prod;
          state <= MUL_RUNS;
        end
        MUL_RUNS: begin
          // low digit and zero digits leave the run count alone
          if (!first && (d != '0)) begin
            runs <= prod + (low_all_max ? '0 : M_W'(d));
          end
          if (d != base - BW'(1)) begin
            low_all_max <= 1'b0;
          end
          first <= 1'b0;
          state <= TEST;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// testbench for binomial_nondivisible_counts: drives bounds and radixes through start/busy,
// predicts the miss, hit and interval counts locally and checks each done strobe in order
// depends on bnc_pkg and the block's rtl
module tb_top;
  import bnc_pkg::*;

  localparam int RADIX_CAP = 16;
  localparam int DRAIN_CYCLES = 800;
  localparam logic [M_W-1:0] ALL_ONES = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  operands_t operands = '0;
  logic      busy;
  logic      done;
  result_t   result;

  result_t expected_counts[$];
  int      error_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;

  binomial_nondivisible_counts #(.MAX_BASE(RADIX_CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [M_W-1:0] effective_radix(input logic [RADIX_W-1:0] rdx);
    if (rdx < 2) return 2;
    if (rdx > RADIX_CAP) return RADIX_CAP;
    return rdx;
  endfunction

  function automatic result_t predict_counts(input operands_t op);
    result_t     r;
    logic [M_W-1:0] b, q, d, miss, runs;
    bit          below_all_max;
    int          pos;
    b = effective_radix(op.radix);
    q = op.m_value;
    miss = 1;
    runs = 0;
    below_all_max = 1'b1;
    pos = 0;
    while (q != 0) begin
      d = q % b;
      q = q / b;
      miss = miss * (d + 1);
      // the +d term is dropped while every lower digit is b-1
      if (pos > 0 && d != 0)
        runs = (d + 1) * runs + (below_all_max ? '0 : d);
      if (d != b - 1)
        below_all_max = 1'b0;
      pos++;
    end
    r.miss_total     = miss;
    r.hit_total      = op.m_value - miss + 1;
    r.interval_total = runs;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [M_W-1:0] want,
                             input logic [M_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_counts.size() == 0) begin
        error_count++;
        $display("%0t: result with no transfer pending, expected none actual %h",
                 $time, result);
      end else begin
        want = expected_counts.pop_front();
        check_field("miss_total", want.miss_total, result.miss_total);
        check_field("hit_total", want.hit_total, result.hit_total);
        check_field("interval_total", want.interval_total, result.interval_total);
      end
    end
  end

  // start stays high across back-to-back transfers; it only drops for an idle gap
  task automatic send_item(input logic [M_W-1:0] m, input logic [RADIX_W-1:0] rdx,
                           input int idle_pct);
    operands_t op;
    operands_t junk;
    int        gap;
    op.m_value = m;
    op.radix   = rdx;
    operands <= op;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    expected_counts = {expected_counts, predict_counts(op)};
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(400, 31) : $urandom_range(30, 1);
      junk.m_value = {$urandom, $urandom};
      junk.radix   = RADIX_W'($urandom_range(31, 0));
      start    <= 1'b0;
      operands <= junk;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_values();
    send_item(64'd0, 2, 0);
    send_item(64'd0, 16, 0);
    send_item(64'd1, 2, 0);
    send_item(64'd1, 0, 0);
    send_item(64'd5, 1, 0);
    send_item(64'd3, 2, 0);
    send_item(ALL_ONES, 2, 0);
    send_item(ALL_ONES, 16, 0);
    send_item(ALL_ONES, 3, 0);
    send_item(ALL_ONES, 31, 0);
    send_item(64'h8000_0000_0000_0000, 2, 0);
    send_item(64'h8000_0000_0000_0000, 17, 0);
    send_item(64'd1000000, 10, 0);
    send_item(64'd999999, 10, 0);
    send_item(64'd48, 7, 0);
    send_item(64'd49, 7, 0);
    send_item(64'd50, 7, 0);
    send_item(64'hFFFF_FFFF, 16, 0);
    send_item(64'h1_0000_0000, 16, 0);
    send_item(64'h5555_5555_5555_5555, 4, 0);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 2, 0);
  endtask

  // bounds assembled digit by digit, leaning on zero and b-1 digits and
  // on runs of b-1 at the low end
  task automatic test_digit_patterns(input int idle_pct, input int count);
    logic [M_W-1:0]     b, m, top, d;
    logic [RADIX_W-1:0] rdx;
    int                 cap, ndig, low_run, kind;
    repeat (count) begin
      rdx = ($urandom_range(9, 0) == 0) ? RADIX_W'($urandom_range(31, 0)) :
                                          RADIX_W'($urandom_range(RADIX_CAP, 2));
      b = effective_radix(rdx);
      cap = 0;
      top = 1;
      while (top <= ALL_ONES / b) begin
        top = top * b;
        cap++;
      end
      ndig = ($urandom_range(3, 0) == 0) ? cap : $urandom_range(cap, 1);
      low_run = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(ndig, 0);
      m = 0;
      for (int i = ndig - 1; i >= 0; i--) begin
        kind = $urandom_range(3, 0);
        if (i < low_run || kind == 0) d = b - 1;
        else if (kind == 1) d = 0;
        else d = M_W'($urandom_range(int'(b) - 1, 0));
        m = m * b + d;
      end
      send_item(m, rdx, idle_pct);
    end
  endtask

  task automatic test_random_bounds(input int idle_pct, input int count);
    logic [M_W-1:0]     m;
    logic [RADIX_W-1:0] rdx;
    repeat (count) begin
      m = {$urandom, $urandom};
      if ($urandom_range(3, 0) != 0) m = m >> $urandom_range(63, 0);
      rdx = ($urandom_range(6, 0) == 0) ? RADIX_W'($urandom_range(31, 0)) :
                                          RADIX_W'($urandom_range(RADIX_CAP, 2));
      send_item(m, rdx, idle_pct);
    end
  endtask

  // let the pipeline empty, hold off, then restart with a long item
  task automatic test_quiet_restart();
    wait_drained();
    repeat ($urandom_range(30, 1)) @(posedge clk);
    send_item(ALL_ONES, 2, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_corner_values();
    test_digit_patterns(0, 280);
    test_random_bounds(0, 170);
    test_quiet_restart();
    test_digit_patterns(64, 280);
    test_random_bounds(64, 170);
    test_quiet_restart();
    test_digit_patterns(26, 230);
    test_random_bounds(26, 150);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transfers and %0d results: radix 0..31 with clamping,", items_sent,
             results_seen);
    $display("digit runs of zero and b-1, full-width bounds, idle gaps of 0, 64 and 26 pct");
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d results still pending", expected_counts.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
